// ----- design/wgm_pkg.sv -----
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants for the glob matcher
// Opcodes, symbol classes and the token that moves down the cell chain.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_FINISH = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_LETTER = 2'd0,
        KIND_ANY    = 2'd1,
        KIND_STAR   = 2'd2,
        KIND_BAD    = 2'd3
    } sym_kind_t;

    typedef struct packed {
        logic       valid;
        opcode_t    op;
        logic [7:0] sym;
        logic       fault;
        logic       left_old;
        logic       left_new;
        logic       placed;
    } token_t;

    function automatic sym_kind_t sym_kind(input logic [7:0] s);
        sym_kind_t k;
        if ((s >= 8'h41 && s <= 8'h5A) || (s >= 8'h61 && s <= 8'h7A)) begin
            k = KIND_LETTER;
        end
        else if (s == SYM_ANY) begin
            k = KIND_ANY;
        end
        else if (s == SYM_STAR) begin
            k = KIND_STAR;
        end
        else begin
            k = KIND_BAD;
        end
        return k;
    endfunction

endpackage

// ----- design/wildcard_glob_matcher.sv -----
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: streaming glob matcher on a chain of pattern cells
// A finish transfer passes the PATTERN_MAX cell registers and then the result
// register; a waiting result that is not taken holds the whole chain.
// Throughput: one item per cycle unless a waiting result holds the chain;
// each item moves one cell per cycle down PATTERN_MAX cells, one per pattern column.
// Reset: empty pattern, fault clear, match row at the empty text, no result.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] symbol,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       matched,
    output logic       pattern_fault
);

    token_t chain [PATTERN_MAX + 1];
    logic   advance;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   matched_reg;
    logic   fault_reg;
    token_t last;

    assign advance    = !result_valid_reg || result_ready;
    assign item_ready = advance;

    wgm_head #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_head (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (item_valid && advance),
        .opcode (opcode),
        .symbol (symbol),
        .token  (chain[0])
    );

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        wgm_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i + 1])
        );
    end

    assign last = chain[PATTERN_MAX];

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance) begin
            result_valid_next = last.valid && (last.op == OP_FINISH);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end
        else begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            matched_reg <= last.left_old && !last.fault;
            fault_reg   <= last.fault;
        end
    end

    assign result_valid  = result_valid_reg;
    assign matched       = matched_reg;
    assign pattern_fault = fault_reg;

endmodule

// ----- design/wgm_head.sv -----
// ----------------------------------------------------------------------------
// wgm_head: front of the cell chain
// Tracks pattern length, fault flag and the empty-text column, and turns each
// accepted input transfer into a token for the first cell.
// ----------------------------------------------------------------------------
module wgm_head
    import wgm_pkg::*;
#(
    parameter int PATTERN_MAX = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [1:0] opcode,
    input  logic [7:0] symbol,
    output token_t     token
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(PATTERN_MAX);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          fault_reg;
    logic          fault_next;
    logic          start_reg;
    logic          start_next;
    opcode_t       op;
    logic          full;

    assign op   = opcode_t'(opcode);
    assign full = (count_reg == COUNT_FULL);

    always_comb
    begin
        count_next     = count_reg;
        fault_next     = fault_reg;
        start_next     = start_reg;
        token.valid    = take;
        token.op       = op;
        token.sym      = symbol;
        token.fault    = fault_reg;
        token.left_old = start_reg;
        token.left_new = 1'b0;
        token.placed   = 1'b0;
        case (op)
            OP_CLEAR:
            begin
                count_next = '0;
                fault_next = 1'b0;
                start_next = 1'b1;
            end
            OP_APPEND:
            begin
                token.left_old = 1'b1;
                start_next     = 1'b1;
                if (full) begin
                    fault_next   = 1'b1;
                    token.placed = 1'b1;
                end
                else begin
                    count_next = count_reg + 1'b1;
                    if (sym_kind(symbol) == KIND_BAD) begin
                        fault_next = 1'b1;
                    end
                end
            end
            OP_TEXT:
            begin
                start_next = 1'b0;
            end
            OP_FINISH:
            begin
                start_next = 1'b1;
            end
            default:
            begin
                start_next = start_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
            fault_reg <= 1'b0;
            start_reg <= 1'b1;
        end
        else if (take) begin
            count_reg <= count_next;
            fault_reg <= fault_next;
            start_reg <= start_next;
        end
    end

endmodule

// ----- design/wgm_cell.sv -----
// ----------------------------------------------------------------------------
// wgm_cell: one pattern column
// Holds one pattern symbol and its match bits; updates them as each token
// passes and hands the token with its column's carries to the next cell.
// ----------------------------------------------------------------------------
module wgm_cell
    import wgm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   advance,
    input  token_t tok_in,
    output token_t tok_out
);

    logic       used_reg;
    logic       used_next;
    logic       empty_reg;
    logic       empty_next;
    logic       cur_reg;
    logic       cur_next;
    logic [7:0] sym_reg;
    logic [7:0] sym_next;
    token_t     tok_reg;
    token_t     tok_next;
    logic       bit_val;

    always_comb
    begin
        case (sym_kind(sym_reg))
            KIND_LETTER: bit_val = (tok_in.sym == sym_reg) && tok_in.left_old;
            KIND_ANY:    bit_val = tok_in.left_old;
            KIND_STAR:   bit_val = tok_in.left_new || cur_reg;
            default:     bit_val = 1'b0;
        endcase
        bit_val = bit_val && used_reg;
    end

    always_comb
    begin
        used_next  = used_reg;
        empty_next = empty_reg;
        cur_next   = cur_reg;
        sym_next   = sym_reg;
        tok_next   = tok_in;
        if (tok_in.valid) begin
            case (tok_in.op)
                OP_CLEAR:
                begin
                    used_next  = 1'b0;
                    empty_next = 1'b0;
                    cur_next   = 1'b0;
                end
                OP_APPEND:
                begin
                    if (!used_reg && !tok_in.placed) begin
                        used_next       = 1'b1;
                        sym_next        = tok_in.sym;
                        empty_next      = tok_in.left_old && (tok_in.sym == SYM_STAR);
                        tok_next.placed = 1'b1;
                    end
                    cur_next          = empty_next;
                    tok_next.left_old = empty_next;
                end
                OP_TEXT:
                begin
                    cur_next          = bit_val;
                    tok_next.left_old = cur_reg;
                    tok_next.left_new = bit_val;
                end
                OP_FINISH:
                begin
                    cur_next = empty_reg;
                    if (used_reg) begin
                        tok_next.left_old = cur_reg;
                    end
                end
                default:
                begin
                    cur_next = cur_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            used_reg  <= 1'b0;
            empty_reg <= 1'b0;
            cur_reg   <= 1'b0;
            sym_reg   <= '0;
            tok_reg   <= '0;
        end
        else if (advance) begin
            used_reg  <= used_next;
            empty_reg <= empty_next;
            cur_reg   <= cur_next;
            sym_reg   <= sym_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ----- sim/wildcard_glob_matcher_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_test: self-checking bench for the streaming glob matcher
// Drives pattern loads, text streams and finish items over the item channel.
// A built-in model predicts each match report. A monitor compares every
// report, field by field, against the oldest prediction. The bench also
// covers random idling on both sides, a long output stall, a sender pause,
// full-length patterns and pattern overflow.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_test;

    import wgm_pkg::*;

    localparam int PATTERN_MAX    = 64;
    localparam int TOTAL_ITEMS    = 1150;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam logic [7:0] SYM_HASH = 8'h23;

    typedef struct {
        bit matched;
        bit fault;
    } verdict_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       item_valid    = 1'b0;
    logic       item_ready;
    logic [1:0] opcode        = OP_CLEAR;
    logic [7:0] symbol        = 8'h00;
    logic       result_valid;
    logic       result_ready  = 1'b0;
    logic       matched;
    logic       pattern_fault;

    verdict_t           verdict_q[$];
    logic [7:0]         pat_mem[PATTERN_MAX];
    int                 pat_len;
    bit                 pat_bad;
    bit [PATTERN_MAX:0] empty_row;
    bit [PATTERN_MAX:0] live_row;

    string alpha = "abAB";
    bit    no_idle;
    int    hold_req;
    int    hold_left;
    int    items_sent;
    int    results_seen;
    int    match_reports;
    int    fault_reports;
    int    mismatch_count;
    int    quiet;

    wildcard_glob_matcher #(
        .PATTERN_MAX (PATTERN_MAX)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .opcode        (opcode),
        .symbol        (symbol),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .matched       (matched),
        .pattern_fault (pattern_fault)
    );

    always #6 clk = ~clk;

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    task automatic glob_advance(input opcode_t op, input logic [7:0] sym);
        bit [PATTERN_MAX:0] row_next;
        verdict_t           v;
        logic [7:0]         p;
        case (op)
            OP_CLEAR:
            begin
                pat_len   = 0;
                pat_bad   = 1'b0;
                empty_row = '0;
                empty_row[0] = 1'b1;
                live_row  = empty_row;
            end
            OP_APPEND:
            begin
                if (pat_len >= PATTERN_MAX)
                begin
                    pat_bad = 1'b1;
                end
                else
                begin
                    if (!is_alpha(sym) && sym != SYM_ANY && sym != SYM_STAR)
                    begin
                        pat_bad = 1'b1;
                    end
                    pat_mem[pat_len] = sym;
                    pat_len++;
                    empty_row[pat_len] = empty_row[pat_len - 1] && (sym == SYM_STAR);
                end
                live_row = empty_row;
            end
            OP_TEXT:
            begin
                row_next = '0;
                for (int j = 1; j <= pat_len; j++)
                begin
                    p = pat_mem[j - 1];
                    if (is_alpha(p))
                    begin
                        row_next[j] = (sym == p) && live_row[j - 1];
                    end
                    else if (p == SYM_ANY)
                    begin
                        row_next[j] = live_row[j - 1];
                    end
                    else if (p == SYM_STAR)
                    begin
                        row_next[j] = row_next[j - 1] || live_row[j];
                    end
                end
                live_row = row_next;
            end
            default:
            begin
                v.matched = live_row[pat_len] && !pat_bad;
                v.fault   = pat_bad;
                verdict_q.push_back(v);
                match_reports += v.matched;
                fault_reports += v.fault;
                live_row = empty_row;
            end
        endcase
    endtask

    // Enter and leave at a falling edge; valid stays high for a back-to-back transfer.
    task automatic send_item(input opcode_t op, input logic [7:0] sym);
        while (!no_idle && $urandom_range(99) < 19)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        symbol     <= sym;
        do @(posedge clk); while (!item_ready);
        glob_advance(op, sym);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_reports();
        item_valid <= 1'b0;
        while (verdict_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic test_directed();
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_FINISH, 8'hFF);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, "a");
        send_item(OP_APPEND, SYM_ANY);
        send_item(OP_APPEND, SYM_STAR);
        send_item(OP_TEXT, "a");
        send_item(OP_TEXT, 8'hFF);
        send_item(OP_FINISH, 8'h55);
        send_item(OP_TEXT, "A");
        send_item(OP_TEXT, "b");
        send_item(OP_FINISH, 8'hAA);
        send_item(OP_TEXT, "a");
        send_item(OP_APPEND, "B");
        send_item(OP_TEXT, "a");
        send_item(OP_TEXT, "x");
        send_item(OP_TEXT, "B");
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, SYM_HASH);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, SYM_STAR);
        send_item(OP_FINISH, 8'h00);
    endtask

    task automatic test_full_pattern();
        logic [7:0] pat_q[$];
        logic [7:0] s;
        send_item(OP_CLEAR, 8'h00);
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            s = (k % 8 == 3) ? SYM_STAR : (k % 8 == 6) ? SYM_ANY : alpha[k % 4];
            pat_q.push_back(s);
            send_item(OP_APPEND, s);
        end
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (pat_q[k] == SYM_STAR)
            begin
                send_item(OP_TEXT, alpha[k % 4]);
            end
            else if (pat_q[k] == SYM_ANY)
            begin
                send_item(OP_TEXT, 8'h80 | k[7:0]);
            end
            else
            begin
                send_item(OP_TEXT, pat_q[k]);
            end
        end
        send_item(OP_FINISH, 8'h00);
        send_item(OP_TEXT, "a");
        send_item(OP_FINISH, 8'h00);
        send_item(OP_APPEND, "a");
        send_item(OP_TEXT, "a");
        send_item(OP_FINISH, 8'h00);
        send_item(OP_CLEAR, 8'h00);
    endtask

    task automatic run_glob_sequences(input int until_items);
        logic [7:0] pat_q[$];
        logic [7:0] txt[$];
        logic [7:0] s;
        int         len;
        int         r;
        int         idx;
        while (items_sent < until_items)
        begin
            if ($urandom_range(99) < 80)
            begin
                if ($urandom_range(9) != 0)
                begin
                    send_item(OP_CLEAR, 8'($urandom_range(255)));
                end
                len = ($urandom_range(99) < 3) ? $urandom_range(33, PATTERN_MAX)
                                               : $urandom_range(0, 8);
                pat_q.delete();
                for (int k = 0; k < len; k++)
                begin
                    r = $urandom_range(99);
                    if (r < 50)
                        s = alpha[$urandom_range(3)];
                    else if (r < 70)
                        s = SYM_ANY;
                    else if (r < 97)
                        s = SYM_STAR;
                    else
                        s = 8'($urandom_range(255));
                    pat_q.push_back(s);
                    send_item(OP_APPEND, s);
                end
                if (len == PATTERN_MAX && $urandom_range(1) == 1)
                begin
                    send_item(OP_APPEND, 8'($urandom_range(255)));
                end
                repeat ($urandom_range(1, 3))
                begin
                    txt.delete();
                    foreach (pat_q[k])
                    begin
                        if (pat_q[k] == SYM_STAR)
                        begin
                            repeat ($urandom_range(3)) txt.push_back(alpha[$urandom_range(3)]);
                        end
                        else if (is_alpha(pat_q[k]))
                        begin
                            txt.push_back(pat_q[k]);
                        end
                        else
                        begin
                            txt.push_back(8'($urandom_range(255)));
                        end
                    end
                    r = $urandom_range(99);
                    if (r >= 60 && r < 75 && txt.size() > 0)
                    begin
                        idx = $urandom_range(txt.size() - 1);
                        txt[idx] = alpha[$urandom_range(3)];
                    end
                    else if (r >= 75 && r < 85 && txt.size() > 0)
                    begin
                        txt.delete($urandom_range(txt.size() - 1));
                    end
                    else if (r >= 85 && r < 95)
                    begin
                        txt.insert($urandom_range(txt.size()), alpha[$urandom_range(3)]);
                    end
                    else if (r >= 95)
                    begin
                        txt.delete();
                        repeat ($urandom_range(6)) txt.push_back(alpha[$urandom_range(3)]);
                    end
                    foreach (txt[k])
                    begin
                        send_item(OP_TEXT, txt[k]);
                    end
                    send_item(OP_FINISH, 8'($urandom_range(255)));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_item(opcode_t'($urandom_range(3)), 8'($urandom_range(255)));
                end
            end
        end
    endtask

    task automatic test_steady_stream();
        no_idle = 1'b1;
        run_glob_sequences(items_sent + 200);
        no_idle = 1'b0;
    endtask

    task automatic test_output_stall();
        hold_req = 400;
        run_glob_sequences(items_sent + 200);
    endtask

    task automatic test_sender_pause();
        run_glob_sequences(items_sent + 20);
        wait_for_reports();
        run_glob_sequences(items_sent + 20);
    endtask

    // Result side: random idling, long hold on request.
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (no_idle)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= ($urandom_range(99) >= 19);
        end
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (verdict_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected report: matched=%0b pattern_fault=%0b",
                             matched, pattern_fault);
                mismatch_count++;
            end
            else
            begin
                want = verdict_q.pop_front();
                if (matched !== want.matched || pattern_fault !== want.fault)
                begin
                    if (mismatch_count < 10)
                        $display("report %0d: expected matched=%0b pattern_fault=%0b, got %0b %0b",
                                 results_seen, want.matched, want.fault,
                                 matched, pattern_fault);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("wildcard_glob_matcher_test failed");
        $finish;
    end

    initial
    begin
        glob_advance(OP_CLEAR, 8'h00);
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_pattern();
        run_glob_sequences(500);
        test_steady_stream();
        test_output_stall();
        test_sender_pause();
        run_glob_sequences(TOTAL_ITEMS);
        wait_for_reports();
        repeat (PATTERN_MAX + 16) @(posedge clk);
        $display("covered %0d items and %0d reports (%0d matches, %0d with fault)",
                 items_sent, results_seen, match_reports, fault_reports);
        $display("incl. full and overflowing patterns, a long output stall and a sender pause");
        if (mismatch_count == 0 && verdict_q.size() == 0)
        begin
            $display("wildcard_glob_matcher_test passed");
        end
        else
        begin
            $display("wildcard_glob_matcher_test failed");
        end
        $finish;
    end

endmodule
